// ===== src/frie_pkg.sv =====
// Shared types, codes and widths for the four-register instruction executor.
`timescale 1ns / 1ps

package frie_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int CMD_W      = 4;
   localparam int REG_IDX_W  = 2;
   localparam int NUM_REGS   = 4;
   localparam int IMM_W      = 32;
   localparam int OUT_W      = 32;
   localparam int STATUS_W   = 2;
   localparam int FLAG_W     = 2;
   localparam int DIV_CNT_W  = $clog2(DATA_WIDTH + 1);

   typedef enum logic [CMD_W-1:0] {
      CMD_MOV   = 4'd0,
      CMD_INC   = 4'd1,
      CMD_DEC   = 4'd2,
      CMD_ADD   = 4'd3,
      CMD_SUB   = 4'd4,
      CMD_MUL   = 4'd5,
      CMD_DIV   = 4'd6,
      CMD_CMP   = 4'd7,
      CMD_PRINT = 4'd8
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_NOSRC   = 2'd1,
      ST_UNKNOWN = 2'd2,
      ST_DIVZERO = 2'd3
   } status_type;

   typedef enum logic [FLAG_W-1:0] {
      FLAG_EQUAL   = 2'd0,
      FLAG_GREATER = 2'd1,
      FLAG_LESS    = 2'd2
   } flag_type;

   // Classified instruction as it travels from front to back.
   typedef struct packed {
      cmd_type                cmd;
      status_type             status;
      logic [REG_IDX_W-1:0]   dest;
      logic                   src_is_reg;
      logic [REG_IDX_W-1:0]   src;
      logic signed [IMM_W-1:0] imm;
   } entry_type;

   typedef struct packed {
      logic start;
      logic ack;
   } div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// ===== src/frie_queue.sv =====
// Two-entry queue between the front and the back.
`timescale 1ns / 1ps

module frie_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  frie_pkg::entry_type push_data,
   output logic                full,
   input  logic                pop,
   output logic                pop_valid,
   output frie_pkg::entry_type pop_data
);
   import frie_pkg::*;

   entry_type  entries_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full      = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_data  = entries_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== src/frie_front.sv =====
// Front end: accepts instructions, flags malformed ones and queues them.
`timescale 1ns / 1ps

module frie_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [frie_pkg::CMD_W-1:0]          req_command,
   input  logic [frie_pkg::REG_IDX_W-1:0]      req_dest_register,
   input  logic                                req_has_source,
   input  logic                                req_source_is_register,
   input  logic [frie_pkg::REG_IDX_W-1:0]      req_source_register,
   input  logic signed [frie_pkg::IMM_W-1:0]   req_immediate_value,
   input  logic                                q_pop,
   output logic                                q_valid,
   output frie_pkg::entry_type                 q_data
);
   import frie_pkg::*;

   entry_type entry;
   logic      q_full;
   logic      known;
   logic      needs_src;

   assign known     = (req_command <= CMD_PRINT);
   assign needs_src = !(req_command == CMD_INC || req_command == CMD_DEC ||
                        req_command == CMD_PRINT);
   assign req_ready = !q_full;

   always_comb begin
      entry.dest       = req_dest_register;
      entry.src_is_reg = req_source_is_register;
      entry.src        = req_source_register;
      entry.imm        = req_immediate_value;
      if (!known) begin
         entry.cmd    = CMD_MOV;
         entry.status = ST_UNKNOWN;
      end else begin
         entry.cmd    = cmd_type'(req_command);
         entry.status = (needs_src && !req_has_source) ? ST_NOSRC : ST_OK;
      end
   end

   frie_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid),
      .push_data (entry),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_data  (q_data)
   );

endmodule

// ===== src/frie_div.sv =====
// Radix-2 restoring signed divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module frie_div (
   input  logic                            clock,
   input  logic                            reset,
   input  frie_pkg::div_ctrl_type          ctrl,
   input  logic [frie_pkg::DATA_WIDTH-1:0] dividend,
   input  logic [frie_pkg::DATA_WIDTH-1:0] divisor,
   output frie_pkg::div_stat_type          stat,
   output logic [frie_pkg::DATA_WIDTH-1:0] quotient
);
   import frie_pkg::*;

   localparam int W = DATA_WIDTH;

   logic [W:0]         rem_ff, rem_in;
   logic [W-1:0]       quo_ff, quo_in;
   logic [W-1:0]       dvs_ff, dvs_in;
   logic               neg_ff, neg_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [W:0]         shifted;
   logic [W+1:0]       diff;
   logic               na, nb;

   assign na       = dividend[W-1];
   assign nb       = divisor[W-1];
   assign shifted  = {rem_ff[W-1:0], quo_ff[W-1]};
   assign diff     = {1'b0, shifted} - {2'b00, dvs_ff};
   assign quotient = neg_ff ? (~quo_ff + W'(1)) : quo_ff;
   assign stat     = '{busy: busy_ff, done: done_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff && !ctrl.ack;
      if (ctrl.start) begin
         rem_in  = '0;
         quo_in  = na ? (~dividend + W'(1)) : dividend;
         dvs_in  = nb ? (~divisor + W'(1)) : divisor;
         neg_in  = na ^ nb;
         cnt_in  = DIV_CNT_W'(W);
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         if (!diff[W+1]) begin
            rem_in = diff[W:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

endmodule

// ===== src/frie_back.sv =====
// Back end: register file, compare flag, execution and the result register.
`timescale 1ns / 1ps

module frie_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_valid,
   input  frie_pkg::entry_type               q_data,
   output logic                              q_pop,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [frie_pkg::STATUS_W-1:0]     rsp_status,
   output logic                              rsp_print_valid,
   output logic signed [frie_pkg::OUT_W-1:0] rsp_print_value,
   output logic [frie_pkg::FLAG_W-1:0]       rsp_compare_result
);
   import frie_pkg::*;

   localparam int W = DATA_WIDTH;

   typedef enum logic [1:0] {
      S_EXEC = 2'b01,
      S_DIV  = 2'b10
   } state_type;

   state_type            state_ff, state_in;
   logic [W-1:0]         regs_ff [NUM_REGS];
   logic [W-1:0]         wr_data;
   logic                 wr_en;
   logic [REG_IDX_W-1:0] wr_idx;
   logic [REG_IDX_W-1:0] div_dest_ff, div_dest_in;
   flag_type             flag_ff, flag_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           status_ff, status_in;
   logic                 pvalid_ff, pvalid_in;
   logic [OUT_W-1:0]     pvalue_ff, pvalue_in;
   logic                 load;
   logic                 out_free;
   logic [W-1:0]         x, y, prod;
   div_ctrl_type         div_ctrl;
   div_stat_type         div_stat;
   logic [W-1:0]         div_quo;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign x        = regs_ff[q_data.dest];
   assign y        = q_data.src_is_reg ? regs_ff[q_data.src] : W'(q_data.imm);
   assign prod     = x * y;

   always_comb begin
      state_in     = state_ff;
      q_pop        = 1'b0;
      wr_en        = 1'b0;
      wr_idx       = q_data.dest;
      wr_data      = x;
      div_dest_in  = div_dest_ff;
      flag_in      = flag_ff;
      load         = 1'b0;
      status_in    = status_ff;
      pvalid_in    = pvalid_ff;
      pvalue_in    = pvalue_ff;
      div_ctrl     = '{start: 1'b0, ack: 1'b0};
      unique case (state_ff)
         S_EXEC: begin
            if (q_valid && out_free) begin
               q_pop     = 1'b1;
               load      = 1'b1;
               status_in = q_data.status;
               pvalid_in = 1'b0;
               pvalue_in = '0;
               if (q_data.status == ST_OK) begin
                  unique case (q_data.cmd)
                     CMD_MOV: begin
                        wr_en   = 1'b1;
                        wr_data = y;
                     end
                     CMD_INC: begin
                        wr_en   = 1'b1;
                        wr_data = x + W'(1);
                     end
                     CMD_DEC: begin
                        wr_en   = 1'b1;
                        wr_data = x - W'(1);
                     end
                     CMD_ADD: begin
                        wr_en   = 1'b1;
                        wr_data = x + y;
                     end
                     CMD_SUB: begin
                        wr_en   = 1'b1;
                        wr_data = x - y;
                     end
                     CMD_MUL: begin
                        wr_en   = 1'b1;
                        wr_data = prod;
                     end
                     CMD_DIV: begin
                        if (y == '0) begin
                           status_in = ST_DIVZERO;
                        end else begin
                           // result is delivered once the divider finishes
                           load           = 1'b0;
                           div_ctrl.start = 1'b1;
                           div_dest_in    = q_data.dest;
                           state_in       = S_DIV;
                        end
                     end
                     CMD_CMP: begin
                        if (x == y) begin
                           flag_in = FLAG_EQUAL;
                        end else if ($signed(x) > $signed(y)) begin
                           flag_in = FLAG_GREATER;
                        end else begin
                           flag_in = FLAG_LESS;
                        end
                     end
                     CMD_PRINT: begin
                        pvalid_in = 1'b1;
                        pvalue_in = OUT_W'($signed(x));
                     end
                     default: begin
                        status_in = ST_UNKNOWN;
                     end
                  endcase
               end
            end
         end
         S_DIV: begin
            if (div_stat.done && out_free) begin
               div_ctrl.ack = 1'b1;
               wr_en        = 1'b1;
               wr_idx       = div_dest_ff;
               wr_data      = div_quo;
               load         = 1'b1;
               status_in    = ST_OK;
               pvalid_in    = 1'b0;
               pvalue_in    = '0;
               state_in     = S_EXEC;
            end
         end
         default: begin
            state_in = S_EXEC;
         end
      endcase
   end

   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_EXEC;
         flag_ff      <= FLAG_EQUAL;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_REGS; i++) begin
            regs_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         flag_ff      <= flag_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en) begin
            regs_ff[wr_idx] <= wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      div_dest_ff <= div_dest_in;
      if (load) begin
         status_ff <= status_in;
         pvalid_ff <= pvalid_in;
         pvalue_ff <= pvalue_in;
      end
   end

   frie_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .dividend (x),
      .divisor  (y),
      .stat     (div_stat),
      .quotient (div_quo)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_print_valid    = pvalid_ff;
   assign rsp_print_value    = pvalue_ff;
   assign rsp_compare_result = flag_ff;

endmodule

// ===== src/four_register_instruction_executor_top.sv =====
// Top level of the four-register instruction executor.
//
// Each req transaction carries one decoded instruction; each one produces
// exactly one rsp transaction, in order, with status, print data and the
// compare flag as it stands after that instruction.
// The front end classifies an instruction and pushes it into a two-entry
// queue; req_ready is low only while that queue is full.
// The back end pops one instruction, reads its operands from the four registers,
// executes and loads the result register; rsp_valid rises once it is there.
// A divide with a nonzero divisor first waits for the radix-2 divider, which
// resolves one quotient bit per cycle. Throughput is one instruction per cycle
// for all other instructions while the result register is free; during a
// divide the back end pops no new instruction.
// When the receiver holds rsp_ready low the result register holds, the back
// end stops popping, and once the queue fills req_ready drops.
// Synchronous reset clears the registers A..D and the compare flag to zero
// and empties the queue and result register; nothing is pending after it.
`timescale 1ns / 1ps

module four_register_instruction_executor_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [frie_pkg::CMD_W-1:0]        req_command,
   input  logic [frie_pkg::REG_IDX_W-1:0]    req_dest_register,
   input  logic                              req_has_source,
   input  logic                              req_source_is_register,
   input  logic [frie_pkg::REG_IDX_W-1:0]    req_source_register,
   input  logic signed [frie_pkg::IMM_W-1:0] req_immediate_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [frie_pkg::STATUS_W-1:0]     rsp_status,
   output logic                              rsp_print_valid,
   output logic signed [frie_pkg::OUT_W-1:0] rsp_print_value,
   output logic [frie_pkg::FLAG_W-1:0]       rsp_compare_result
);
   import frie_pkg::*;

   entry_type q_data;
   logic      q_valid;
   logic      q_pop;

   frie_front u_front (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_command            (req_command),
      .req_dest_register      (req_dest_register),
      .req_has_source         (req_has_source),
      .req_source_is_register (req_source_is_register),
      .req_source_register    (req_source_register),
      .req_immediate_value    (req_immediate_value),
      .q_pop                  (q_pop),
      .q_valid                (q_valid),
      .q_data                 (q_data)
   );

   frie_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_valid            (q_valid),
      .q_data             (q_data),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_print_valid    (rsp_print_valid),
      .rsp_print_value    (rsp_print_value),
      .rsp_compare_result (rsp_compare_result)
   );

endmodule

// ===== src/frie_checker.sv =====
// Port-level assertions for the executor top, attached by bind.
`timescale 1ns / 1ps

module frie_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [frie_pkg::STATUS_W-1:0]     rsp_status,
   input logic                              rsp_print_valid,
   input logic signed [frie_pkg::OUT_W-1:0] rsp_print_value,
   input logic [frie_pkg::FLAG_W-1:0]       rsp_compare_result
);
   import frie_pkg::*;

   // a stalled response transaction must keep its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_print_value) && $stable(rsp_compare_result))
      else $error("stalled response changed");

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_print_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_print_valid |-> rsp_status == ST_OK)
      else $error("print with error status");

   a_print_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_print_valid |-> rsp_print_value == '0)
      else $error("print value nonzero without print");

   a_flag_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_compare_result != 2'd3)
      else $error("invalid compare flag");

endmodule

bind four_register_instruction_executor_top frie_checker u_frie_checker (.*);
